// ===== sv/hav_pkg.sv =====
// hav_pkg: shared types, widths and constants of the haversine distance pipeline
// used by every cell module and the top level; depends on nothing
`default_nettype none

package hav_pkg;

  // cordic depth, valid from 12 to 40
  localparam int CORDIC_STAGES = 24;
  localparam int IDX_W = 6;

  // cordic datapath width, q30 values with guard bits
  localparam int CW = 34;

  // degrees to binary angle: floor((k * |deg| + 45) / 90), 4 dividend bits per cell
  localparam int NUM_W     = 40;
  localparam int DIV_BITS  = 4;
  localparam int DIV_CELLS = NUM_W / DIV_BITS;
  localparam int REM_W     = 7;
  localparam int ANG_W     = 32;
  localparam logic [REM_W:0]   DIV_D    = 8'd90;
  localparam logic [NUM_W-1:0] NUM_BIAS = 40'd45;

  // integer square root of (a << 30), one root bit per cell
  localparam int SQ_ROOT_W  = 31;
  localparam int SQ_REM_W   = 61;
  localparam int SQ_TRIAL_W = 63;
  localparam int SQ_IDX_W   = 5;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] rem;
    logic [ANG_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic                 vld;
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                 vld;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sqrt_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      6'd0:    r = 34'sd843314857;
      6'd1:    r = 34'sd497837829;
      6'd2:    r = 34'sd263043837;
      6'd3:    r = 34'sd133525159;
      6'd4:    r = 34'sd67021687;
      6'd5:    r = 34'sd33543516;
      6'd6:    r = 34'sd16775851;
      6'd7:    r = 34'sd8388437;
      6'd8:    r = 34'sd4194283;
      6'd9:    r = 34'sd2097149;
      default: begin
        if (i <= 6'd30) r = {{(CW-1){1'b0}}, 1'b1} << (6'd30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hav_div_cell.sv =====
// hav_div_cell: one cell of the constant divide-by-90 chain, four dividend bits per cell
// depends on hav_pkg
`default_nettype none

module hav_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  hav_pkg::div_t d_in,
  output hav_pkg::div_t d_out
);
  import hav_pkg::*;

  div_t d_nxt;
  div_t d_r;

  always_comb begin
    logic [REM_W:0]   r8;
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] rem;
    logic [ANG_W-1:0] q;
    num = d_in.num;
    rem = d_in.rem;
    q   = d_in.q;
    for (int j = 0; j < DIV_BITS; j++) begin
      r8  = {rem, num[NUM_W-1]};
      num = num << 1;
      if (r8 >= DIV_D) begin
        r8 = r8 - DIV_D;
        q  = {q[ANG_W-2:0], 1'b1};
      end else begin
        q  = {q[ANG_W-2:0], 1'b0};
      end
      rem = r8[REM_W-1:0];
    end
    d_nxt     = d_in;
    d_nxt.num = num;
    d_nxt.rem = rem;
    d_nxt.q   = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

`default_nettype wire

// ===== sv/hav_cordic_cell.sv =====
// hav_cordic_cell: one micro-rotation of a cordic chain, rotation or vectoring mode
// depends on hav_pkg (cordic_t, atan_q30)
`default_nettype none

module hav_cordic_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vec_mode,
  input  logic [hav_pkg::IDX_W-1:0] idx,
  input  hav_pkg::cordic_t          d_in,
  output hav_pkg::cordic_t          d_out
);
  import hav_pkg::*;

  cordic_t d_nxt;
  cordic_t d_r;

  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    logic                 neg;
    dx  = d_in.y >>> idx;
    dy  = d_in.x >>> idx;
    at  = atan_q30(idx);
    // vectoring drives y toward zero, rotation drives z toward zero
    neg = vec_mode ? (d_in.y > 0) : d_in.z[CW-1];
    d_nxt = d_in;
    if (neg) begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end else begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

`default_nettype wire

// ===== sv/hav_sqrt_cell.sv =====
// hav_sqrt_cell: one root bit of a digit-by-digit integer square root chain
// depends on hav_pkg (sqrt_t)
`default_nettype none

module hav_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [hav_pkg::SQ_IDX_W-1:0] idx,
  input  hav_pkg::sqrt_t               d_in,
  output hav_pkg::sqrt_t               d_out
);
  import hav_pkg::*;

  sqrt_t d_nxt;
  sqrt_t d_r;

  always_comb begin
    logic [SQ_TRIAL_W-1:0] trial;
    logic                  ge;
    // (2*root + 2^b) * 2^b, the growth of root^2 when bit b is set
    trial = (SQ_TRIAL_W'(d_in.root) << ({1'b0, idx} + 6'd1))
          + (SQ_TRIAL_W'(1) << {idx, 1'b0});
    ge    = SQ_TRIAL_W'(d_in.rem) >= trial;
    d_nxt = d_in;
    if (ge) begin
      d_nxt.rem  = d_in.rem - trial[SQ_REM_W-1:0];
      d_nxt.root = d_in.root | (SQ_ROOT_W'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

`default_nettype wire

// ===== sv/haversine_distance_top.sv =====
// haversine_distance_top: great-circle distance pipeline, one point pair per cycle
// throughput one item per cycle; the whole chain advances when the output register is free
// synchronous active-low reset clears every valid bit and loads earth_radius with 3959
// depends on hav_pkg, hav_div_cell, hav_cordic_cell, hav_sqrt_cell
`default_nettype none

module haversine_distance_top (
  input  logic               clk,
  input  logic               rst_n,
  // point pair items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [29:0] in_first_lat,
  input  logic signed [30:0] in_first_lon,
  input  logic signed [29:0] in_second_lat,
  input  logic signed [30:0] in_second_lon,
  // distance items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [33:0]        out_distance,
  // radius register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_earth_radius
);
  import hav_pkg::*;

  localparam int LANES = 4;
  localparam int DEG_W = 33;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
  localparam logic [ANG_W-2:0]   HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // pipeline advance: every stage moves when the output register can take an item
  logic en;
  logic out_vld_r;
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  // items in flight, at most one per register stage
  logic [7:0] inflight_r;
  logic [7:0] inflight_nxt;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_valid && in_ready) inflight_nxt = inflight_nxt + 8'd1;
    if (out_valid && out_ready) inflight_nxt = inflight_nxt - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 8'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // radius register, written only while the pipeline is empty and no item is offered
  logic [15:0] earth_radius_r;
  assign cfg_ready = (inflight_r == 8'd0) && !in_valid;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earth_radius_r <= 16'd3959;
    end else if (cfg_valid && cfg_ready) begin
      earth_radius_r <= cfg_earth_radius;
    end
  end

  // ---------------------------------------------------------------------------
  // input stage: latitude delta, longitude delta, both latitudes
  // ---------------------------------------------------------------------------
  logic                    s0_vld_r;
  logic signed [DEG_W-1:0] s0_deg_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_deg_r[0] <= DEG_W'(in_second_lat) - DEG_W'(in_first_lat);
      s0_deg_r[1] <= DEG_W'(in_second_lon) - DEG_W'(in_first_lon);
      s0_deg_r[2] <= DEG_W'(in_first_lat);
      s0_deg_r[3] <= DEG_W'(in_second_lat);
    end
  end

  // ---------------------------------------------------------------------------
  // degrees to binary angle: deltas are half angles (x128/90), latitudes x256/90
  // ---------------------------------------------------------------------------
  div_t div_c [LANES][DIV_CELLS+1];

  for (genvar l = 0; l < LANES; l++) begin : g_div
    always_comb begin
      logic             neg;
      logic [ANG_W-1:0] mag;
      neg = s0_deg_r[l][DEG_W-1];
      mag = neg ? ANG_W'(-s0_deg_r[l]) : ANG_W'(s0_deg_r[l]);
      div_c[l][0].vld = s0_vld_r;
      div_c[l][0].neg = neg;
      div_c[l][0].num = (NUM_W'(mag) << ((l < 2) ? 7 : 8)) + NUM_BIAS;
      div_c[l][0].rem = '0;
      div_c[l][0].q   = '0;
    end

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
      hav_div_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d_in  (div_c[l][k]),
        .d_out (div_c[l][k+1])
      );
    end
  end

  // signed binary angle, modulo one turn
  logic             t_vld_r;
  logic [ANG_W-1:0] t_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= div_c[0][DIV_CELLS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        t_r[l] <= div_c[l][DIV_CELLS].neg ? (ANG_W'(0) - div_c[l][DIV_CELLS].q)
                                          : div_c[l][DIV_CELLS].q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // quadrant fold into +-90 degrees, then binary angle to q30 radians
  // ---------------------------------------------------------------------------
  logic             p1_vld_r;
  logic [ANG_W-1:0] p1_m_r    [LANES];
  logic             p1_sgn_r  [LANES];
  logic             p1_flip_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= t_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [ANG_W-1:0] tp;
    logic [ANG_W-1:0] tf;
    logic             flip;
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        tp   = t_r[l] + 32'h4000_0000;
        flip = tp[ANG_W-1];
        // adding half a turn only toggles the top bit
        tf   = flip ? (t_r[l] ^ 32'h8000_0000) : t_r[l];
        p1_flip_r[l] <= flip;
        p1_sgn_r[l]  <= tf[ANG_W-1];
        p1_m_r[l]    <= tf[ANG_W-1] ? (ANG_W'(0) - tf) : tf;
      end
    end
  end

  logic                    p2_vld_r;
  logic [ANG_W+ANG_W-2:0]  p2_prod_r [LANES];
  logic                    p2_sgn_r  [LANES];
  logic                    p2_flip_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        p2_prod_r[l] <= 63'(p1_m_r[l]) * 63'(HALF_PI_Q30);
        p2_sgn_r[l]  <= p1_sgn_r[l];
        p2_flip_r[l] <= p1_flip_r[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // rotation cordic lanes: sin/cos of half deltas and of both latitudes
  // ---------------------------------------------------------------------------
  cordic_t rot_c [LANES][CORDIC_STAGES+1];

  for (genvar l = 0; l < LANES; l++) begin : g_rot
    always_comb begin
      logic [63:0]    zsum;
      logic [CW-1:0]  zmag;
      zsum = 64'(p2_prod_r[l]) + 64'(HALF_Q30);
      zmag = zsum[30+CW-1:30];
      rot_c[l][0].vld  = p2_vld_r;
      rot_c[l][0].flip = p2_flip_r[l];
      rot_c[l][0].x    = GAIN_Q30;
      rot_c[l][0].y    = '0;
      rot_c[l][0].z    = p2_sgn_r[l] ? -$signed(zmag) : $signed(zmag);
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      hav_cordic_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec_mode (1'b0),
        .idx      (IDX_W'(k)),
        .d_in     (rot_c[l][k]),
        .d_out    (rot_c[l][k+1])
      );
    end
  end

  // sine of the half deltas, cosine of the latitudes, quadrant fold undone
  logic               n_vld_r;
  logic signed [31:0] n_sl_r;
  logic signed [31:0] n_slo_r;
  logic signed [31:0] n_c1_r;
  logic signed [31:0] n_c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else if (en) begin
      n_vld_r <= rot_c[0][CORDIC_STAGES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_sl_r  <= 32'(rot_c[0][CORDIC_STAGES].flip ? -rot_c[0][CORDIC_STAGES].y
                                                   : rot_c[0][CORDIC_STAGES].y);
      n_slo_r <= 32'(rot_c[1][CORDIC_STAGES].flip ? -rot_c[1][CORDIC_STAGES].y
                                                   : rot_c[1][CORDIC_STAGES].y);
      n_c1_r  <= 32'(rot_c[2][CORDIC_STAGES].flip ? -rot_c[2][CORDIC_STAGES].x
                                                   : rot_c[2][CORDIC_STAGES].x);
      n_c2_r  <= 32'(rot_c[3][CORDIC_STAGES].flip ? -rot_c[3][CORDIC_STAGES].x
                                                   : rot_c[3][CORDIC_STAGES].x);
    end
  end

  // ---------------------------------------------------------------------------
  // haversine term a = sl^2 + c1*c2*slo^2, each product rounded to q30
  // ---------------------------------------------------------------------------
  logic               m1_vld_r;
  logic signed [63:0] m1_cc_r;
  logic signed [63:0] m1_lo_r;
  logic signed [63:0] m1_l_r;
  logic               m2_vld_r;
  logic signed [31:0] m2_cc_r;
  logic signed [31:0] m2_lo_r;
  logic signed [31:0] m2_l_r;
  logic               m3_vld_r;
  logic signed [63:0] m3_p_r;
  logic signed [31:0] m3_l_r;
  logic               m4_vld_r;
  logic [30:0]        m4_a_r;
  logic [30:0]        m4_na_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= n_vld_r;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] a34;
    if (en) begin
      m1_cc_r <= n_c1_r * n_c2_r;
      m1_lo_r <= n_slo_r * n_slo_r;
      m1_l_r  <= n_sl_r * n_sl_r;

      m2_cc_r <= 32'((m1_cc_r + HALF_Q30) >>> 30);
      m2_lo_r <= 32'((m1_lo_r + HALF_Q30) >>> 30);
      m2_l_r  <= 32'((m1_l_r + HALF_Q30) >>> 30);

      m3_p_r  <= m2_cc_r * m2_lo_r;
      m3_l_r  <= m2_l_r;

      // clamp to 0..1 so the roots stay real
      a34 = 34'((m3_p_r + HALF_Q30) >>> 30) + 34'(m3_l_r);
      if (a34 < 0) a34 = '0;
      if (a34 > ONE_Q30) a34 = ONE_Q30;
      m4_a_r  <= a34[30:0];
      m4_na_r <= ONE_Q30[30:0] - a34[30:0];
    end
  end

  // ---------------------------------------------------------------------------
  // square roots of a and 1 - a, one root bit per cell
  // ---------------------------------------------------------------------------
  sqrt_t sq_c [2][SQ_ROOT_W+1];

  always_comb begin
    sq_c[0][0].vld  = m4_vld_r;
    sq_c[0][0].rem  = {m4_a_r, 30'd0};
    sq_c[0][0].root = '0;
    sq_c[1][0].vld  = m4_vld_r;
    sq_c[1][0].rem  = {m4_na_r, 30'd0};
    sq_c[1][0].root = '0;
  end

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_cell
      hav_sqrt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .idx   (SQ_IDX_W'(SQ_ROOT_W - 1 - k)),
        .d_in  (sq_c[l][k]),
        .d_out (sq_c[l][k+1])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // vectoring cordic: atan2(sqrt(a), sqrt(1 - a)) gives half the central angle
  // ---------------------------------------------------------------------------
  cordic_t vec_c [CORDIC_STAGES+1];

  always_comb begin
    vec_c[0].vld  = sq_c[0][SQ_ROOT_W].vld;
    vec_c[0].flip = 1'b0;
    vec_c[0].x    = CW'(sq_c[1][SQ_ROOT_W].root);
    vec_c[0].y    = CW'(sq_c[0][SQ_ROOT_W].root);
    vec_c[0].z    = '0;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    hav_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vec_mode (1'b1),
      .idx      (IDX_W'(k)),
      .d_in     (vec_c[k]),
      .d_out    (vec_c[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // scale by radius: (radius * angle + 2^12) >> 13, saturating at 34 bits
  // ---------------------------------------------------------------------------
  logic        f1_vld_r;
  logic [46:0] f1_prod_r;
  logic [33:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r  <= vec_c[CORDIC_STAGES].vld;
      out_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [30:0] zc;
    logic [47:0] dsum;
    if (en) begin
      // coincident points can leave a tiny negative angle
      zc = vec_c[CORDIC_STAGES].z[CW-1] ? 31'd0 : vec_c[CORDIC_STAGES].z[30:0];
      f1_prod_r <= 47'(earth_radius_r) * 47'(zc);
      dsum = 48'(f1_prod_r) + 48'd4096;
      out_dist_r <= dsum[47] ? '1 : dsum[46:13];
    end
  end

  assign out_valid    = out_vld_r;
  assign out_distance = out_dist_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_term_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    m4_vld_r |-> (m4_a_r <= ONE_Q30[30:0]) && (31'(m4_a_r + m4_na_r) == ONE_Q30[30:0]))
    else $error("haversine term outside 0..1");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sq_c[0][SQ_ROOT_W].vld |->
      (sq_c[0][SQ_ROOT_W].root <= 31'h4000_0000) && (sq_c[1][SQ_ROOT_W].root <= 31'h4000_0000))
    else $error("square root above one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p2_vld_r) && $stable(m4_a_r) && $stable(f1_prod_r))
    else $error("pipeline moved while stalled");

  a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_dist_r != '1)
    else $error("distance saturated");

endmodule

`default_nettype wire

// ===== sim/haversine_distance_checker.sv =====
// haversine_distance_checker: watches the point pair, distance and radius channels,
// predicts every distance in fixed point and compares; depends on hav_pkg (stage count)
module haversine_distance_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [29:0] in_first_lat,
  input  logic signed [30:0] in_first_lon,
  input  logic signed [29:0] in_second_lat,
  input  logic signed [30:0] in_second_lon,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [33:0]        out_distance,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_earth_radius,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q30 = 64'sd1 << 30;
  localparam longint HALF = 64'sd1 << 29;
  localparam longint GAIN = 64'sd652032874;
  localparam longint HPI = 64'sd1686629713;

  logic [15:0] radius;
  logic [33:0] dist_q[$];

  function automatic longint atan_step(int i);
    longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF) >>> 30;
  endfunction

  // degrees q22 scaled by mul/360, rounded half away from zero, as a binary angle
  function automatic logic [31:0] deg_to_turns(longint deg, longint mul);
    longint unsigned m, q;
    m = (deg < 0) ? -deg : deg;
    q = (m * mul + 180) / 360;
    if (deg < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic void rotate(input logic [31:0] t, output longint s, output longint c);
    logic flip;
    longint a, z, x, y, dx, dy;
    longint unsigned m;
    flip = ((t + 32'h4000_0000) & 32'h8000_0000) != 0;
    x = GAIN;
    y = 0;
    if (flip) t = t + 32'h8000_0000;
    a = longint'($signed(t));
    m = (a < 0) ? -a : a;
    m = (m * HPI + (64'd1 << 29)) >> 30;
    z = (a < 0) ? -longint'(m) : longint'(m);
    for (int i = 0; i < hav_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [33:0] predict_distance(longint lat1, longint lon1,
                                                   longint lat2, longint lon2,
                                                   logic [15:0] rad);
    longint sl, cl, slo, clo, s1, c1, s2, c2, p, a, x, y, z, dx, dy;
    longint unsigned d;
    rotate(deg_to_turns(lat2 - lat1, 512), sl, cl);
    rotate(deg_to_turns(lon2 - lon1, 512), slo, clo);
    rotate(deg_to_turns(lat1, 1024), s1, c1);
    rotate(deg_to_turns(lat2, 1024), s2, c2);
    p = qmul(qmul(c1, c2), qmul(slo, slo));
    a = qmul(sl, sl) + p;
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    y = int_root(longint'(a) << 30);
    x = int_root(longint'(Q30 - a) << 30);
    z = 0;
    for (int i = 0; i < hav_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    if (z < 0) z = 0;
    d = (longint'(rad) * z + (64'd1 << 12)) >> 13;
    if (d > 64'h3_FFFF_FFFF) d = 64'h3_FFFF_FFFF;
    return d[33:0];
  endfunction

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      radius <= 16'd3959;
      dist_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) radius <= cfg_earth_radius;
      if (in_valid && in_ready)
        dist_q.push_back(predict_distance(in_first_lat, in_first_lon, in_second_lat,
                                          in_second_lon, radius));
      if (out_valid && out_ready) begin
        if (dist_q.size() == 0) begin
          $error("unexpected distance item %0d", out_distance);
          fail_count++;
        end else if (out_distance !== dist_q[0]) begin
          $error("distance: expected %0d, actual %0d", dist_q[0], out_distance);
          fail_count++;
          void'(dist_q.pop_front());
        end else begin
          void'(dist_q.pop_front());
        end
      end
    end
    pending <= dist_q.size();
  end
endmodule

// ===== sim/haversine_distance_top_tb.sv =====
// haversine_distance_top_tb: drives point pairs, radius writes and output stalls
// into haversine_distance_top; checking lives in haversine_distance_checker
module haversine_distance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_MAX = 377487360;
  localparam int LON_MAX = 754974720;
  localparam int LATENCY = 52 + 2 * hav_pkg::CORDIC_STAGES;
  localparam int WATCHDOG = 20000;
  localparam logic [15:0] RADII [4] = '{16'd1, 16'd65535, 16'd6371, 16'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [29:0] in_first_lat = '0;
  logic signed [30:0] in_first_lon = '0;
  logic signed [29:0] in_second_lat = '0;
  logic signed [30:0] in_second_lon = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [33:0] out_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_earth_radius = '0;
  int fail_count;
  int pending;

  // output stall control
  bit quiet = 1'b0;      // last stretch: no stalls
  bit hold_off = 1'b0;   // long receiver stall
  int idle_cycles = 0;

  always #5 clk = ~clk;

  haversine_distance_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_lat(in_first_lat), .in_first_lon(in_first_lon),
    .in_second_lat(in_second_lat), .in_second_lon(in_second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance(out_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_earth_radius(cfg_earth_radius)
  );

  haversine_distance_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_lat(in_first_lat), .in_first_lon(in_first_lon),
    .in_second_lat(in_second_lat), .in_second_lon(in_second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance(out_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_earth_radius(cfg_earth_radius),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stall bursts, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      idle_cycles <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles with no handshake on any channel
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  // present one point pair and hold it until accepted
  task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2);
    in_valid <= 1'b1;
    in_first_lat <= 30'(lat1);
    in_first_lon <= 31'(lon1);
    in_second_lat <= 30'(lat2);
    in_second_lon <= 31'(lon2);
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and idle for a random burst, unless idling is off
  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // radius write while the pipe is empty
  task automatic write_radius(input logic [15:0] r);
    cfg_valid <= 1'b1;
    cfg_earth_radius <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_span(int lim);
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  // random pair: mostly in range, some anywhere in the field width
  task automatic send_random();
    if ($urandom_range(0, 9) == 0)
      send_pair($urandom(), $urandom(), $urandom(), $urandom());
    else if ($urandom_range(0, 9) == 0) begin
      int lat, lon;
      lat = rand_span(LAT_MAX);
      lon = rand_span(LON_MAX);
      // near-coincident points
      send_pair(lat, lon, lat + rand_span(16), lon + rand_span(16));
    end else
      send_pair(rand_span(LAT_MAX), rand_span(LON_MAX), rand_span(LAT_MAX), rand_span(LON_MAX));
    sender_gap();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs at the default radius
    send_pair(0, 0, 0, 0);                             // coincident points
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);                // pole to pole
    send_pair(0, -LON_MAX, 0, LON_MAX);                // across the date line
    send_pair(0, 0, 0, LON_MAX);                       // antipodal on the equator
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(536870911, 1073741823, -536870912, -1073741824);
    send_pair(-536870912, -1073741824, 536870911, 1073741823);
    send_pair(1, 1, 0, 0);                             // tiny separation
    send_pair(-1, -1, 1, 1);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);    // both at a pole
    send_pair(12345678, -98765432, 12345678, -98765432);
    drain();

    // radius phases: the extremes 1 and 65535, then 6371, then zero
    for (int k = 0; k < 4; k++) begin
      write_radius(RADII[k]);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      repeat (80) send_random();
      drain();
    end
    write_radius(16'd3959);

    // receiver held off while items keep coming: pipe fills, input stalls
    hold_off = 1'b1;
    fork
      repeat (2 * LATENCY) send_random();
      repeat (3 * LATENCY) @(posedge clk);
    join_any
    hold_off = 1'b0;
    wait fork;
    // sender pauses until everything has come back
    drain();

    // last stretch with no idling
    quiet = 1'b1;
    repeat (110) send_random();
    drain();

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

// ===== files.f =====
sv/hav_pkg.sv
sv/hav_div_cell.sv
sv/hav_cordic_cell.sv
sv/hav_sqrt_cell.sv
sv/haversine_distance_top.sv
sim/haversine_distance_checker.sv
sim/haversine_distance_top_tb.sv
